@@ hdl/assert_macros.svh @@
// assertion macros of the slip detector rtl, used by its top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSD_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define WSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/wsd_pkg.sv @@
// shared types and constants of the wheel slip detector
package wsd_pkg;

	localparam int LEVEL_W = 15;
	localparam int TICK_W  = 8;
	localparam int WHEELS  = 4;

	localparam logic [TICK_W-1:0] CONFIRM_TICKS       = 8'd10;
	localparam logic [TICK_W-1:0] BAD_FIXES_TO_LATCH  = 8'd3;
	localparam logic [TICK_W-1:0] GOOD_FIXES_TO_CLEAR = 8'd3;
	localparam int CULPRIT_DEADBAND = 64;
	localparam logic [17:0] DEADBAND_X2 = 18'(2 * CULPRIT_DEADBAND);

	localparam logic [2:0] UNKNOWN_WHEEL = 3'd4;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7fff;
	localparam logic [TICK_W-1:0] COUNT_MAX = 8'hff;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [15:0] ALPHA_RST       = 16'd6554;
	localparam logic [14:0] KIN_ON_RST      = 15'd256;
	localparam logic [14:0] KIN_OFF_RST     = 15'd128;
	localparam logic [14:0] YAW_ON_RST      = 15'd128;
	localparam logic [14:0] YAW_OFF_RST     = 15'd64;
	localparam logic [15:0] INNOV_ENTER_RST = 16'd2048;
	localparam logic [15:0] INNOV_EXIT_RST  = 16'd1024;
	localparam logic [14:0] STILL_SPEED_RST = 15'd26;

	typedef enum logic [2:0] {
		REG_EWMA_ALPHA  = 3'd0,
		REG_KIN_ON      = 3'd1,
		REG_KIN_OFF     = 3'd2,
		REG_YAW_ON      = 3'd3,
		REG_YAW_OFF     = 3'd4,
		REG_INNOV_ENTER = 3'd5,
		REG_INNOV_EXIT  = 3'd6,
		REG_STILL_SPEED = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [15:0] ewma_alpha;
		logic [14:0] kin_on_th;
		logic [14:0] kin_off_th;
		logic [14:0] yaw_on_th;
		logic [14:0] yaw_off_th;
		logic [15:0] innov_enter;
		logic [15:0] innov_exit;
		logic [14:0] still_speed;
	} cfg_t;

	typedef struct packed {
		logic signed [WHEELS-1:0][15:0] speed;
		logic signed [WHEELS-1:0][15:0] current;
		logic signed [15:0] consistency_error;
		logic signed [15:0] yaw_mismatch;
		logic [15:0] innovation;
		logic innovation_fresh;
	} in_item_t;

	typedef struct packed {
		logic slip_kinematic;
		logic slip_innovation;
		logic slip_gyro;
		logic [2:0] culprit_wheel;
		logic [LEVEL_W-1:0] kinematic_level;
		logic [LEVEL_W-1:0] yaw_level;
	} out_item_t;

	typedef struct packed {
		logic latch;
		logic [TICK_W-1:0] ticks;
	} hyst_state_t;

endpackage

@@ hdl/wsd_in_if.sv @@
// input channel of the slip detector: one sensor tick per item
interface wsd_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] speed_w0;
	logic signed [15:0] speed_w1;
	logic signed [15:0] speed_w2;
	logic signed [15:0] speed_w3;
	logic signed [15:0] current_w0;
	logic signed [15:0] current_w1;
	logic signed [15:0] current_w2;
	logic signed [15:0] current_w3;
	logic signed [15:0] consistency_error;
	logic signed [15:0] yaw_mismatch;
	logic [15:0] innovation;
	logic innovation_fresh;

	modport source (
		output valid, speed_w0, speed_w1, speed_w2, speed_w3,
		output current_w0, current_w1, current_w2, current_w3,
		output consistency_error, yaw_mismatch, innovation, innovation_fresh,
		input ready
	);
	modport sink (
		input valid, speed_w0, speed_w1, speed_w2, speed_w3,
		input current_w0, current_w1, current_w2, current_w3,
		input consistency_error, yaw_mismatch, innovation, innovation_fresh,
		output ready
	);
endinterface

@@ hdl/wsd_out_if.sv @@
// result channel of the slip detector: flags, culprit and levels per item
interface wsd_out_if;
	logic valid;
	logic ready;
	logic slip_kinematic;
	logic slip_innovation;
	logic slip_gyro;
	logic [2:0] culprit_wheel;
	logic [wsd_pkg::LEVEL_W-1:0] kinematic_level;
	logic [wsd_pkg::LEVEL_W-1:0] yaw_level;

	modport source (
		output valid, slip_kinematic, slip_innovation, slip_gyro,
		output culprit_wheel, kinematic_level, yaw_level,
		input ready
	);
	modport sink (
		input valid, slip_kinematic, slip_innovation, slip_gyro,
		input culprit_wheel, kinematic_level, yaw_level,
		output ready
	);
endinterface

@@ hdl/wsd_cfg.sv @@
// apb configuration registers of the slip detector
module wsd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wsd_pkg::PADDR_W-1:0]  paddr,
	input  logic [wsd_pkg::PDATA_W-1:0]  pwdata,
	output logic [wsd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output wsd_pkg::cfg_t                cfg
);

	wsd_pkg::cfg_t    cfg_q;
	wsd_pkg::cfg_reg_e sel;
	logic             wr_en;

	assign sel    = wsd_pkg::cfg_reg_e'(paddr[4:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ewma_alpha  <= wsd_pkg::ALPHA_RST;
			cfg_q.kin_on_th   <= wsd_pkg::KIN_ON_RST;
			cfg_q.kin_off_th  <= wsd_pkg::KIN_OFF_RST;
			cfg_q.yaw_on_th   <= wsd_pkg::YAW_ON_RST;
			cfg_q.yaw_off_th  <= wsd_pkg::YAW_OFF_RST;
			cfg_q.innov_enter <= wsd_pkg::INNOV_ENTER_RST;
			cfg_q.innov_exit  <= wsd_pkg::INNOV_EXIT_RST;
			cfg_q.still_speed <= wsd_pkg::STILL_SPEED_RST;
		end else if (wr_en) begin
			unique case (sel)
				wsd_pkg::REG_EWMA_ALPHA:  cfg_q.ewma_alpha  <= pwdata[15:0];
				wsd_pkg::REG_KIN_ON:      cfg_q.kin_on_th   <= pwdata[14:0];
				wsd_pkg::REG_KIN_OFF:     cfg_q.kin_off_th  <= pwdata[14:0];
				wsd_pkg::REG_YAW_ON:      cfg_q.yaw_on_th   <= pwdata[14:0];
				wsd_pkg::REG_YAW_OFF:     cfg_q.yaw_off_th  <= pwdata[14:0];
				wsd_pkg::REG_INNOV_ENTER: cfg_q.innov_enter <= pwdata[15:0];
				wsd_pkg::REG_INNOV_EXIT:  cfg_q.innov_exit  <= pwdata[15:0];
				wsd_pkg::REG_STILL_SPEED: cfg_q.still_speed <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (sel)
			wsd_pkg::REG_EWMA_ALPHA:  prdata = {16'h0, cfg_q.ewma_alpha};
			wsd_pkg::REG_KIN_ON:      prdata = {17'h0, cfg_q.kin_on_th};
			wsd_pkg::REG_KIN_OFF:     prdata = {17'h0, cfg_q.kin_off_th};
			wsd_pkg::REG_YAW_ON:      prdata = {17'h0, cfg_q.yaw_on_th};
			wsd_pkg::REG_YAW_OFF:     prdata = {17'h0, cfg_q.yaw_off_th};
			wsd_pkg::REG_INNOV_ENTER: prdata = {16'h0, cfg_q.innov_enter};
			wsd_pkg::REG_INNOV_EXIT:  prdata = {16'h0, cfg_q.innov_exit};
			wsd_pkg::REG_STILL_SPEED: prdata = {17'h0, cfg_q.still_speed};
			default:                  prdata = '0;
		endcase
	end

endmodule

@@ hdl/wsd_ewma.sv @@
// first-order ewma step on the saturated magnitude of a signed sample
module wsd_ewma (
	input  logic [15:0]                 alpha,
	input  logic [wsd_pkg::LEVEL_W-1:0] level,
	input  logic signed [15:0]          sample,
	output logic [wsd_pkg::LEVEL_W-1:0] level_next
);

	logic [16:0]        mag;
	logic [14:0]        target;
	logic signed [16:0] d;
	logic signed [33:0] prod;
	logic signed [33:0] p;
	logic signed [17:0] q;
	logic signed [18:0] n;

	always_comb begin
		mag    = sample[15] ? (~{sample[15], sample} + 17'd1) : {sample[15], sample};
		target = (mag > {2'b00, wsd_pkg::LEVEL_MAX}) ? wsd_pkg::LEVEL_MAX : mag[14:0];
		d      = $signed({2'b00, target}) - $signed({2'b00, level});
		prod   = $signed({1'b0, alpha}) * d;
		// round to nearest, ties up; floor via the upper bits
		p      = prod + 34'sd32768;
		q      = p[33:16];
		n      = $signed({4'b0000, level}) + $signed({q[17], q});
		if (n[18])
			level_next = '0;
		else if (n[17:15] != 3'b000)
			level_next = wsd_pkg::LEVEL_MAX;
		else
			level_next = n[14:0];
	end

endmodule

@@ hdl/wsd_hyst.sv @@
// hysteresis trip with tick confirmation, cleared when standing still
module wsd_hyst (
	input  logic [wsd_pkg::LEVEL_W-1:0] level,
	input  logic [14:0]                 enter,
	input  logic [14:0]                 exitv,
	input  logic                        clear,
	input  wsd_pkg::hyst_state_t        cur,
	output wsd_pkg::hyst_state_t        nxt
);

	logic [14:0]               th;
	logic [wsd_pkg::TICK_W-1:0] inc;

	always_comb begin
		th  = cur.latch ? exitv : enter;
		inc = (cur.ticks == wsd_pkg::COUNT_MAX) ? cur.ticks : cur.ticks + 8'd1;
		if (clear) begin
			nxt.ticks = '0;
			nxt.latch = 1'b0;
		end else if (level > th) begin
			nxt.ticks = inc;
			nxt.latch = cur.latch || (inc >= wsd_pkg::CONFIRM_TICKS);
		end else begin
			nxt.ticks = '0;
			nxt.latch = 1'b0;
		end
	end

endmodule

@@ hdl/wsd_culprit.sv @@
// culprit wheel by deviation of |current| from the median |current|
module wsd_culprit (
	input  logic signed [wsd_pkg::WHEELS-1:0][15:0] current,
	input  logic                                    front_fast,
	output logic [2:0]                              culprit
);

	logic [16:0]        mag [wsd_pkg::WHEELS];
	logic [18:0]        sum;
	logic [16:0]        mn;
	logic [16:0]        mx;
	logic [17:0]        med2;
	logic signed [18:0] dev2;
	logic signed [18:0] score;
	logic signed [18:0] best;
	logic [2:0]         idx;

	always_comb begin
		sum = '0;
		for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
			mag[i] = current[i][15] ? (~{current[i][15], current[i]} + 17'd1)
			                        : {current[i][15], current[i]};
			sum = sum + {2'b00, mag[i]};
		end
		mn = mag[0];
		mx = mag[0];
		for (int i = 1; i < wsd_pkg::WHEELS; i++) begin
			if (mag[i] < mn) mn = mag[i];
			if (mag[i] > mx) mx = mag[i];
		end
		// doubled median: sum of the two middle magnitudes
		med2 = 18'(sum - {2'b00, mn} - {2'b00, mx});
		best = '0;
		idx  = wsd_pkg::UNKNOWN_WHEEL;
		dev2 = '0;
		score = '0;
		for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
			dev2  = $signed({1'b0, mag[i], 1'b0}) - $signed({1'b0, med2});
			// front wheels score low current when front runs fast, rear the opposite
			score = (front_fast == (i < 2)) ? -dev2 : dev2;
			if (score > best) begin
				best = score;
				idx  = 3'(i);
			end
		end
		culprit = (best >= $signed({1'b0, wsd_pkg::DEADBAND_X2})) ? idx
		                                                          : wsd_pkg::UNKNOWN_WHEEL;
	end

endmodule

@@ hdl/wheel_slip_detector.sv @@
// top level of the wheel slip detector: input register, update logic, result register
//
//  channel   dir   handshake          payload
//  in_ch     in    valid/ready        4 speeds, 4 currents, errors, innovation
//  out_ch    out   valid/ready        3 flags, culprit wheel, 2 levels
//  apb       in    psel/penable       8 config registers at 4*i
//
// one item per cycle sustained while out_ch is not stalled
// all state updates in the same cycle an item moves from the input register
// into the result register (two ewma multiplies, median and hysteresis logic)
// a stalled result holds a full input register; an empty one still takes one more item
// reset clears all levels, counters and latches; config registers take reset values
module wheel_slip_detector (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [wsd_pkg::PADDR_W-1:0]  paddr,
	input  logic [wsd_pkg::PDATA_W-1:0]  pwdata,
	output logic [wsd_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	wsd_in_if.sink                       in_ch,
	wsd_out_if.source                    out_ch
);

	`include "assert_macros.svh"

	wsd_pkg::cfg_t        cfg;
	wsd_pkg::in_item_t    item_s1;
	logic                 valid_s1;
	wsd_pkg::out_item_t   res_q;
	logic                 out_valid_q;
	logic                 advance;
	logic                 take;

	logic [wsd_pkg::LEVEL_W-1:0] kin_level_q, yaw_level_q;
	logic [wsd_pkg::LEVEL_W-1:0] kin_level_nx, yaw_level_nx;
	wsd_pkg::hyst_state_t        kin_q, yaw_q, kin_nx, yaw_nx;
	logic [wsd_pkg::TICK_W-1:0]  bad_q, good_q, bad_nx, good_nx;
	logic                        innov_q, innov_nx;
	logic [16:0]                 peak;
	logic [16:0]                 smag;
	logic                        standing;
	logic [2:0]                  pick;
	wsd_pkg::out_item_t          res_nx;

	wsd_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.speed             <= {in_ch.speed_w3, in_ch.speed_w2,
			                              in_ch.speed_w1, in_ch.speed_w0};
			item_s1.current           <= {in_ch.current_w3, in_ch.current_w2,
			                              in_ch.current_w1, in_ch.current_w0};
			item_s1.consistency_error <= in_ch.consistency_error;
			item_s1.yaw_mismatch      <= in_ch.yaw_mismatch;
			item_s1.innovation        <= in_ch.innovation;
			item_s1.innovation_fresh  <= in_ch.innovation_fresh;
		end
	end

	wsd_ewma u_ewma_kin (
		.alpha(cfg.ewma_alpha), .level(kin_level_q),
		.sample(item_s1.consistency_error), .level_next(kin_level_nx)
	);

	wsd_ewma u_ewma_yaw (
		.alpha(cfg.ewma_alpha), .level(yaw_level_q),
		.sample(item_s1.yaw_mismatch), .level_next(yaw_level_nx)
	);

	always_comb begin
		peak = '0;
		smag = '0;
		for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
			smag = item_s1.speed[i][15] ? (~{item_s1.speed[i][15], item_s1.speed[i]} + 17'd1)
			                            : {item_s1.speed[i][15], item_s1.speed[i]};
			if (smag > peak) peak = smag;
		end
		standing = peak < {2'b00, cfg.still_speed};
	end

	wsd_hyst u_hyst_kin (
		.level(kin_level_nx), .enter(cfg.kin_on_th), .exitv(cfg.kin_off_th),
		.clear(standing), .cur(kin_q), .nxt(kin_nx)
	);

	wsd_hyst u_hyst_yaw (
		.level(yaw_level_nx), .enter(cfg.yaw_on_th), .exitv(cfg.yaw_off_th),
		.clear(standing), .cur(yaw_q), .nxt(yaw_nx)
	);

	wsd_culprit u_culprit (
		.current(item_s1.current),
		.front_fast(!item_s1.consistency_error[15] && (item_s1.consistency_error != 16'sd0)),
		.culprit(pick)
	);

	// fix counting, then the standing-still clear overrides it
	always_comb begin
		bad_nx   = bad_q;
		good_nx  = good_q;
		innov_nx = innov_q;
		if (item_s1.innovation_fresh) begin
			if (item_s1.innovation > cfg.innov_enter) begin
				bad_nx  = (bad_q == wsd_pkg::COUNT_MAX) ? bad_q : bad_q + 8'd1;
				good_nx = '0;
			end else if (item_s1.innovation < cfg.innov_exit) begin
				good_nx = (good_q == wsd_pkg::COUNT_MAX) ? good_q : good_q + 8'd1;
				bad_nx  = '0;
			end
			if (bad_nx >= wsd_pkg::BAD_FIXES_TO_LATCH) innov_nx = 1'b1;
			if (good_nx >= wsd_pkg::GOOD_FIXES_TO_CLEAR) innov_nx = 1'b0;
		end
		if (standing) begin
			bad_nx   = '0;
			good_nx  = '0;
			innov_nx = 1'b0;
		end
	end

	always_comb begin
		res_nx.slip_kinematic  = kin_nx.latch;
		res_nx.slip_innovation = innov_nx;
		res_nx.slip_gyro       = yaw_nx.latch;
		res_nx.culprit_wheel   = kin_nx.latch ? pick : wsd_pkg::UNKNOWN_WHEEL;
		res_nx.kinematic_level = kin_level_nx;
		res_nx.yaw_level       = yaw_level_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kin_level_q <= '0;
			yaw_level_q <= '0;
			kin_q       <= '0;
			yaw_q       <= '0;
			bad_q       <= '0;
			good_q      <= '0;
			innov_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				kin_level_q <= kin_level_nx;
				yaw_level_q <= yaw_level_nx;
				kin_q       <= kin_nx;
				yaw_q       <= yaw_nx;
				bad_q       <= bad_nx;
				good_q      <= good_nx;
				innov_q     <= innov_nx;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_nx;
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.slip_kinematic  = res_q.slip_kinematic;
	assign out_ch.slip_innovation = res_q.slip_innovation;
	assign out_ch.slip_gyro       = res_q.slip_gyro;
	assign out_ch.culprit_wheel   = res_q.culprit_wheel;
	assign out_ch.kinematic_level = res_q.kinematic_level;
	assign out_ch.yaw_level       = res_q.yaw_level;

	`WSD_ASSERT(a_culprit_needs_kin, clk, arst_n,
		out_valid_q && (res_q.culprit_wheel != wsd_pkg::UNKNOWN_WHEEL),
		res_q.slip_kinematic, "culprit reported without kinematic latch")
	`WSD_ASSERT_NEXT(a_state_holds, clk, arst_n, !advance,
		$stable(kin_q) && $stable(yaw_q) && $stable(innov_q) && $stable(kin_level_q),
		"detector state changed without an item")
	`WSD_ASSERT_NEXT(a_result_lands, clk, arst_n, advance, out_valid_q,
		"advanced item did not reach the result register")
	`WSD_ASSERT(a_empty_takes, clk, arst_n, !valid_s1, in_ch.ready,
		"empty input register refused an item")

endmodule

@@ tb/wheel_slip_detector_tb.sv @@
// self-checking testbench of the wheel slip detector: predicted flags, culprit and levels per sensor tick
module wheel_slip_detector_tb;

	localparam int HOLD_CYCLES = 60;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 185;
	localparam int DIRECTED_TICKS = 25;

	typedef enum int {
		DRIVE_CRUISE,
		DRIVE_SLIP,
		DRIVE_YAW,
		DRIVE_STILL,
		DRIVE_NOISE
	} drive_mode_e;

	class slip_scoreboard;
		wsd_pkg::cfg_t cfg;
		int kin_lvl, yaw_lvl;
		int kin_ticks, yaw_ticks;
		int bad_fixes, good_fixes;
		bit kin_latched, yaw_latched, innov_latched;
		wsd_pkg::out_item_t due_reports[$];
		int mismatches;

		function new();
			cfg.ewma_alpha  = wsd_pkg::ALPHA_RST;
			cfg.kin_on_th   = wsd_pkg::KIN_ON_RST;
			cfg.kin_off_th  = wsd_pkg::KIN_OFF_RST;
			cfg.yaw_on_th   = wsd_pkg::YAW_ON_RST;
			cfg.yaw_off_th  = wsd_pkg::YAW_OFF_RST;
			cfg.innov_enter = wsd_pkg::INNOV_ENTER_RST;
			cfg.innov_exit  = wsd_pkg::INNOV_EXIT_RST;
			cfg.still_speed = wsd_pkg::STILL_SPEED_RST;
			mismatches = 0;
		endfunction

		function void set_reg(wsd_pkg::cfg_reg_e r, logic [31:0] v);
			case (r)
				wsd_pkg::REG_EWMA_ALPHA:  cfg.ewma_alpha  = v[15:0];
				wsd_pkg::REG_KIN_ON:      cfg.kin_on_th   = v[14:0];
				wsd_pkg::REG_KIN_OFF:     cfg.kin_off_th  = v[14:0];
				wsd_pkg::REG_YAW_ON:      cfg.yaw_on_th   = v[14:0];
				wsd_pkg::REG_YAW_OFF:     cfg.yaw_off_th  = v[14:0];
				wsd_pkg::REG_INNOV_ENTER: cfg.innov_enter = v[15:0];
				wsd_pkg::REG_INNOV_EXIT:  cfg.innov_exit  = v[15:0];
				wsd_pkg::REG_STILL_SPEED: cfg.still_speed = v[14:0];
				default: ;
			endcase
		endfunction

		function int magnitude16(logic [15:0] v);
			int s;
			s = int'($signed(v));
			return (s < 0) ? -s : s;
		endfunction

		function int sat_inc(int c);
			return (c < int'(wsd_pkg::COUNT_MAX)) ? c + 1 : int'(wsd_pkg::COUNT_MAX);
		endfunction

		// step rounded to nearest, ties up, then clamped to the level range
		function int filter_step(int lvl, int tgt);
			longint p, n;
			p = longint'(cfg.ewma_alpha) * longint'(tgt - lvl) + 64'sd32768;
			n = longint'(lvl) + (p >>> 16);
			if (n < 0)
				n = 0;
			if (n > longint'(wsd_pkg::LEVEL_MAX))
				n = longint'(wsd_pkg::LEVEL_MAX);
			return int'(n);
		endfunction

		function bit hyst_update(int lvl, int enter_th, int exit_th, bit latched, inout int ticks);
			int th;
			th = latched ? exit_th : enter_th;
			if (lvl > th) begin
				ticks = sat_inc(ticks);
				return latched || (ticks >= int'(wsd_pkg::CONFIRM_TICKS));
			end
			ticks = 0;
			return 1'b0;
		endfunction

		// deviation from the doubled median current, sign flipped by which axle runs fast
		function int pick_wheel(bit front_fast, int mags[wsd_pkg::WHEELS]);
			int sum, mn, mx, med2, dev2, score, best, idx;
			sum = 0;
			mn = mags[0];
			mx = mags[0];
			for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
				sum += mags[i];
				if (mags[i] < mn)
					mn = mags[i];
				if (mags[i] > mx)
					mx = mags[i];
			end
			med2 = sum - mn - mx;
			best = 0;
			idx = int'(wsd_pkg::UNKNOWN_WHEEL);
			for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
				dev2 = 2 * mags[i] - med2;
				score = (front_fast == (i < 2)) ? -dev2 : dev2;
				if (score > best) begin
					best = score;
					idx = i;
				end
			end
			return (best >= 2 * wsd_pkg::CULPRIT_DEADBAND) ? idx : int'(wsd_pkg::UNKNOWN_WHEEL);
		endfunction

		function void take_tick(wsd_pkg::in_item_t t);
			int peak, tgt, culprit;
			int mags[wsd_pkg::WHEELS];
			wsd_pkg::out_item_t e;
			peak = 0;
			for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
				if (magnitude16(t.speed[i]) > peak)
					peak = magnitude16(t.speed[i]);
				mags[i] = magnitude16(t.current[i]);
			end
			tgt = magnitude16(t.consistency_error);
			if (tgt > int'(wsd_pkg::LEVEL_MAX))
				tgt = int'(wsd_pkg::LEVEL_MAX);
			kin_lvl = filter_step(kin_lvl, tgt);
			tgt = magnitude16(t.yaw_mismatch);
			if (tgt > int'(wsd_pkg::LEVEL_MAX))
				tgt = int'(wsd_pkg::LEVEL_MAX);
			yaw_lvl = filter_step(yaw_lvl, tgt);

			if (t.innovation_fresh) begin
				if (int'(t.innovation) > int'(cfg.innov_enter)) begin
					bad_fixes = sat_inc(bad_fixes);
					good_fixes = 0;
				end else if (int'(t.innovation) < int'(cfg.innov_exit)) begin
					good_fixes = sat_inc(good_fixes);
					bad_fixes = 0;
				end
				if (bad_fixes >= int'(wsd_pkg::BAD_FIXES_TO_LATCH))
					innov_latched = 1'b1;
				if (good_fixes >= int'(wsd_pkg::GOOD_FIXES_TO_CLEAR))
					innov_latched = 1'b0;
			end

			culprit = int'(wsd_pkg::UNKNOWN_WHEEL);
			// standing still overrides everything, levels keep filtering
			if (peak < int'(cfg.still_speed)) begin
				kin_ticks = 0;
				yaw_ticks = 0;
				bad_fixes = 0;
				good_fixes = 0;
				kin_latched = 1'b0;
				yaw_latched = 1'b0;
				innov_latched = 1'b0;
			end else begin
				kin_latched = hyst_update(kin_lvl, int'(cfg.kin_on_th), int'(cfg.kin_off_th),
					kin_latched, kin_ticks);
				yaw_latched = hyst_update(yaw_lvl, int'(cfg.yaw_on_th), int'(cfg.yaw_off_th),
					yaw_latched, yaw_ticks);
				if (kin_latched)
					culprit = pick_wheel($signed(t.consistency_error) > 0, mags);
			end

			e.slip_kinematic  = kin_latched;
			e.slip_innovation = innov_latched;
			e.slip_gyro       = yaw_latched;
			e.culprit_wheel   = 3'(culprit);
			e.kinematic_level = kin_lvl[14:0];
			e.yaw_level       = yaw_lvl[14:0];
			due_reports.push_back(e);
		endfunction

		function void field_check(string name, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, seen);
				mismatches++;
			end
		endfunction

		function void check_report(wsd_pkg::out_item_t got);
			wsd_pkg::out_item_t e;
			if (due_reports.size() == 0) begin
				$error("report with no tick pending");
				mismatches++;
				return;
			end
			e = due_reports.pop_front();
			field_check("slip_kinematic", 16'(e.slip_kinematic), 16'(got.slip_kinematic));
			field_check("slip_innovation", 16'(e.slip_innovation), 16'(got.slip_innovation));
			field_check("slip_gyro", 16'(e.slip_gyro), 16'(got.slip_gyro));
			field_check("culprit_wheel", 16'(e.culprit_wheel), 16'(got.culprit_wheel));
			field_check("kinematic_level", 16'(e.kinematic_level), 16'(got.kinematic_level));
			field_check("yaw_level", 16'(e.yaw_level), 16'(got.yaw_level));
		endfunction

		function int outstanding();
			return due_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [wsd_pkg::PADDR_W-1:0] paddr;
	logic [wsd_pkg::PDATA_W-1:0] pwdata;
	logic [wsd_pkg::PDATA_W-1:0] prdata;
	logic pready;

	wsd_in_if tick_if();
	wsd_out_if report_if();

	slip_scoreboard sb;
	bit no_idle = 1'b0;
	bit hold_off = 1'b0;
	int burst_left = 0;

	wheel_slip_detector dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (tick_if),
		.out_ch  (report_if)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("[wheel_slip_detector] ERROR");
		$finish;
	end

	always @(posedge clk) begin : watch
		wsd_pkg::in_item_t tick;
		wsd_pkg::out_item_t got;
		if (arst_n) begin
			if (tick_if.valid && tick_if.ready) begin
				tick.speed[0] = tick_if.speed_w0;
				tick.speed[1] = tick_if.speed_w1;
				tick.speed[2] = tick_if.speed_w2;
				tick.speed[3] = tick_if.speed_w3;
				tick.current[0] = tick_if.current_w0;
				tick.current[1] = tick_if.current_w1;
				tick.current[2] = tick_if.current_w2;
				tick.current[3] = tick_if.current_w3;
				tick.consistency_error = tick_if.consistency_error;
				tick.yaw_mismatch = tick_if.yaw_mismatch;
				tick.innovation = tick_if.innovation;
				tick.innovation_fresh = tick_if.innovation_fresh;
				sb.take_tick(tick);
			end
			if (report_if.valid && report_if.ready) begin
				got.slip_kinematic  = report_if.slip_kinematic;
				got.slip_innovation = report_if.slip_innovation;
				got.slip_gyro       = report_if.slip_gyro;
				got.culprit_wheel   = report_if.culprit_wheel;
				got.kinematic_level = report_if.kinematic_level;
				got.yaw_level       = report_if.yaw_level;
				sb.check_report(got);
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		report_if.ready = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_off) begin
				report_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end else if (!no_idle && $urandom_range(0, 3) == 0) begin
				report_if.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				report_if.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	function automatic logic [15:0] sat16(int v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return 16'(v);
	endfunction

	function automatic int jitter(int w);
		if (w < 0)
			w = -w;
		return int'($urandom_range(0, 2 * w)) - w;
	endfunction

	function automatic wsd_pkg::in_item_t directed_tick(int k);
		wsd_pkg::in_item_t t;
		t.speed = {4{16'd2560}};
		t.current = {4{16'd256}};
		t.consistency_error = 16'h7fff;
		t.yaw_mismatch = 16'd1000;
		t.innovation = 16'd0;
		t.innovation_fresh = 1'b0;
		if (k == 0) begin
			t = '0;
		end else if (k == 1) begin
			t.speed = {4{16'h7fff}};
			t.current = {4{16'h7fff}};
			t.yaw_mismatch = 16'h7fff;
			t.innovation = 16'hffff;
			t.innovation_fresh = 1'b1;
		end else if (k <= 3) begin
			t.speed = {4{16'h8000}};
			t.current = {4{16'h8000}};
			t.consistency_error = 16'h8000;
			t.yaw_mismatch = 16'h8000;
			t.innovation = 16'hffff;
			t.innovation_fresh = 1'b1;
		end else if (k == 4) begin
			t.innovation = 16'hffff;
			t.innovation_fresh = 1'b1;
		end else if (k <= 13) begin
			// kinematic channel confirms here, good fixes clear the innovation latch
			t.current[k % 4] = k[0] ? 16'h2000 : 16'h8000;
			t.consistency_error = k[0] ? 16'h7fff : 16'h8000;
			t.innovation_fresh = (k >= 11);
		end else if (k <= 19) begin
			t.consistency_error = k[0] ? 16'h7fff : 16'hff00;
			t.current[k % 4] = 16'd4096;
			// tie between all four wheels goes to wheel 0
			if (k == 17) begin
				t.current = {16'd256, 16'd256, 16'd4096, 16'd4096};
				t.consistency_error = 16'h8000;
			end
			// best deviation inside the deadband
			if (k == 18)
				t.current = {16'd256, 16'd256, 16'd300, 16'd256};
			if (k == 19)
				t.current = {4{16'hff00}};
		end else if (k == 20) begin
			// just under min speed while latched, with a bad fix
			t.speed = {16'hffff, 16'd0, 16'hffe7, 16'd25};
			t.innovation = 16'hffff;
			t.innovation_fresh = 1'b1;
		end else if (k == 21) begin
			t.speed = {16'hffe6, 16'd0, 16'd0, 16'd0};
		end else if (k == 22) begin
			t.innovation = wsd_pkg::INNOV_ENTER_RST;
			t.innovation_fresh = 1'b1;
		end else if (k == 23) begin
			t.innovation = wsd_pkg::INNOV_EXIT_RST;
			t.innovation_fresh = 1'b1;
		end else begin
			t.consistency_error = 16'd0;
			t.yaw_mismatch = 16'd0;
			t.innovation = wsd_pkg::INNOV_ENTER_RST + 16'd1;
			t.innovation_fresh = 1'b1;
		end
		return t;
	endfunction

	function automatic wsd_pkg::in_item_t random_tick(drive_mode_e mode, int err_base,
		int yaw_base, bit bad_bias);
		wsd_pkg::in_item_t t;
		int s, base_cur, odd, e, y, ev, xv, nv;
		if (mode == DRIVE_NOISE) begin
			for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
				t.speed[i] = 16'($urandom);
				t.current[i] = 16'($urandom);
			end
			t.consistency_error = 16'($urandom);
			t.yaw_mismatch = 16'($urandom);
			t.innovation = 16'($urandom);
			t.innovation_fresh = 1'($urandom_range(0, 1));
			return t;
		end
		base_cur = $urandom_range(0, 3000);
		odd = $urandom_range(0, wsd_pkg::WHEELS);
		for (int i = 0; i < wsd_pkg::WHEELS; i++) begin
			if (mode == DRIVE_STILL)
				s = $urandom_range(0, 40);
			else if ($urandom_range(0, 7) == 0)
				s = $urandom_range(0, 32767);
			else
				s = $urandom_range(20, 9000);
			t.speed[i] = sat16($urandom_range(0, 1) ? -s : s);
			s = base_cur + $urandom_range(0, 150);
			t.current[i] = (i == odd) ? 16'($urandom) : sat16($urandom_range(0, 1) ? -s : s);
		end
		case (mode)
			DRIVE_SLIP: begin
				e = err_base + jitter(err_base / 8 + 1);
				y = jitter(300);
			end
			DRIVE_YAW: begin
				e = jitter(150);
				y = yaw_base + jitter(yaw_base / 8 + 1);
			end
			DRIVE_STILL: begin
				e = err_base + jitter(200);
				y = yaw_base + jitter(200);
			end
			default: begin
				e = jitter(150);
				y = jitter(150);
			end
		endcase
		t.consistency_error = sat16(e);
		t.yaw_mismatch = sat16(y);

		ev = int'(sb.cfg.innov_enter);
		xv = int'(sb.cfg.innov_exit);
		case ($urandom_range(0, 5))
			0: nv = ev + int'($urandom_range(1, 300));
			1: nv = xv - int'($urandom_range(1, 300));
			2: nv = ev;
			3: nv = xv;
			4: nv = $urandom_range(0, 1) ? 65535 : 0;
			default: nv = $urandom_range(0, 65535);
		endcase
		if (bad_bias && $urandom_range(0, 9) < 7)
			nv = ev + int'($urandom_range(1, 2000));
		if (nv < 0)
			nv = 0;
		if (nv > 65535)
			nv = 65535;
		t.innovation = 16'(nv);
		t.innovation_fresh = bad_bias ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 2) == 0);
		return t;
	endfunction

	function automatic wsd_pkg::cfg_t phase_settings(int p);
		wsd_pkg::cfg_t s;
		logic [127:0] raw;
		if (p == 0) begin
			s.ewma_alpha  = wsd_pkg::ALPHA_RST;
			s.kin_on_th   = wsd_pkg::KIN_ON_RST;
			s.kin_off_th  = wsd_pkg::KIN_OFF_RST;
			s.yaw_on_th   = wsd_pkg::YAW_ON_RST;
			s.yaw_off_th  = wsd_pkg::YAW_OFF_RST;
			s.innov_enter = wsd_pkg::INNOV_ENTER_RST;
			s.innov_exit  = wsd_pkg::INNOV_EXIT_RST;
			s.still_speed = wsd_pkg::STILL_SPEED_RST;
		end else if (p == 1) begin
			s.ewma_alpha  = 16'hffff;
			s.kin_on_th   = '0;
			s.kin_off_th  = '0;
			s.yaw_on_th   = '0;
			s.yaw_off_th  = '0;
			s.innov_enter = '0;
			s.innov_exit  = 16'hffff;
			s.still_speed = '0;
		end else if (p == 2) begin
			s.ewma_alpha  = '0;
			s.kin_on_th   = wsd_pkg::LEVEL_MAX;
			s.kin_off_th  = wsd_pkg::LEVEL_MAX;
			s.yaw_on_th   = wsd_pkg::LEVEL_MAX;
			s.yaw_off_th  = wsd_pkg::LEVEL_MAX;
			s.innov_enter = 16'hffff;
			s.innov_exit  = '0;
			s.still_speed = wsd_pkg::LEVEL_MAX;
		end else if (p == 6) begin
			raw = {$urandom, $urandom, $urandom, $urandom};
			s = raw[$bits(wsd_pkg::cfg_t)-1:0];
		end else begin
			s.ewma_alpha  = 16'($urandom_range(1000, 40000));
			s.kin_on_th   = 15'($urandom_range(64, 4000));
			s.kin_off_th  = 15'($urandom_range(0, s.kin_on_th));
			s.yaw_on_th   = 15'($urandom_range(64, 4000));
			s.yaw_off_th  = 15'($urandom_range(0, s.yaw_on_th));
			s.innov_enter = 16'($urandom_range(512, 8192));
			s.innov_exit  = 16'($urandom_range(0, s.innov_enter));
			s.still_speed = 15'($urandom_range(0, 600));
		end
		return s;
	endfunction

	task automatic apb_write(wsd_pkg::cfg_reg_e r, logic [15:0] v, bit junk);
		logic [31:0] data;
		data = {16'h0, v};
		// unused upper bits must be ignored by the register
		if (junk) begin
			if (r == wsd_pkg::REG_EWMA_ALPHA || r == wsd_pkg::REG_INNOV_ENTER
				|| r == wsd_pkg::REG_INNOV_EXIT)
				data[31:16] = 16'($urandom);
			else
				data[31:15] = 17'($urandom);
		end
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(r, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_settings(wsd_pkg::cfg_t s, bit junk);
		apb_write(wsd_pkg::REG_EWMA_ALPHA, s.ewma_alpha, junk);
		apb_write(wsd_pkg::REG_KIN_ON, {1'b0, s.kin_on_th}, junk);
		apb_write(wsd_pkg::REG_KIN_OFF, {1'b0, s.kin_off_th}, junk);
		apb_write(wsd_pkg::REG_YAW_ON, {1'b0, s.yaw_on_th}, junk);
		apb_write(wsd_pkg::REG_YAW_OFF, {1'b0, s.yaw_off_th}, junk);
		apb_write(wsd_pkg::REG_INNOV_ENTER, s.innov_enter, junk);
		apb_write(wsd_pkg::REG_INNOV_EXIT, s.innov_exit, junk);
		apb_write(wsd_pkg::REG_STILL_SPEED, {1'b0, s.still_speed}, junk);
	endtask

	task automatic send_tick(wsd_pkg::in_item_t t);
		tick_if.valid <= 1'b1;
		tick_if.speed_w0 <= t.speed[0];
		tick_if.speed_w1 <= t.speed[1];
		tick_if.speed_w2 <= t.speed[2];
		tick_if.speed_w3 <= t.speed[3];
		tick_if.current_w0 <= t.current[0];
		tick_if.current_w1 <= t.current[1];
		tick_if.current_w2 <= t.current[2];
		tick_if.current_w3 <= t.current[3];
		tick_if.consistency_error <= t.consistency_error;
		tick_if.yaw_mismatch <= t.yaw_mismatch;
		tick_if.innovation <= t.innovation;
		tick_if.innovation_fresh <= t.innovation_fresh;
		do @(posedge clk); while (!tick_if.ready);
	endtask

	task automatic idle_in(int n);
		tick_if.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if (burst_left > 0)
			burst_left--;
		else if (!no_idle && $urandom_range(0, 5) == 0)
			idle_in($urandom_range(1, 9));
	endtask

	// stop sending and wait until every tick has reported
	task automatic drain_reports();
		tick_if.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (2) @(posedge clk);
	endtask

	initial begin
		int ep_left, ep_err, ep_yaw, pick;
		drive_mode_e ep_mode;
		bit ep_bad;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_if.valid = 1'b0;
		tick_if.speed_w0 = '0;
		tick_if.speed_w1 = '0;
		tick_if.speed_w2 = '0;
		tick_if.speed_w3 = '0;
		tick_if.current_w0 = '0;
		tick_if.current_w1 = '0;
		tick_if.current_w2 = '0;
		tick_if.current_w3 = '0;
		tick_if.consistency_error = '0;
		tick_if.yaw_mismatch = '0;
		tick_if.innovation = '0;
		tick_if.innovation_fresh = 1'b0;
		ep_left = 0;
		ep_err = 0;
		ep_yaw = 0;
		ep_mode = DRIVE_CRUISE;
		ep_bad = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < DIRECTED_TICKS; k++) begin
			send_tick(directed_tick(k));
			maybe_idle();
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_reports();
			write_settings(phase_settings(phase), phase >= 3);
			if (phase == PHASES - 1)
				no_idle = 1'b1;
			// long receiver hold-off while ticks keep coming
			if (phase == 3) begin
				hold_off = 1'b1;
				burst_left = 80;
			end
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if (ep_left == 0) begin
					pick = $urandom_range(0, 9);
					if (pick < 2)
						ep_mode = DRIVE_CRUISE;
					else if (pick < 5)
						ep_mode = DRIVE_SLIP;
					else if (pick < 7)
						ep_mode = DRIVE_YAW;
					else if (pick < 8)
						ep_mode = DRIVE_STILL;
					else
						ep_mode = DRIVE_NOISE;
					ep_err = ($urandom_range(0, 3) == 0) ? $urandom_range(12000, 32767)
						: $urandom_range(100, 6000);
					if ($urandom_range(0, 1))
						ep_err = -ep_err;
					ep_yaw = ($urandom_range(0, 3) == 0) ? $urandom_range(12000, 32767)
						: $urandom_range(100, 6000);
					if ($urandom_range(0, 1))
						ep_yaw = -ep_yaw;
					ep_bad = ($urandom_range(0, 2) == 0);
					ep_left = $urandom_range(4, 40);
				end
				send_tick(random_tick(ep_mode, ep_err, ep_yaw, ep_bad));
				ep_left--;
				if (phase == 5 && n == TICKS_PER_PHASE / 2)
					drain_reports();
				else
					maybe_idle();
			end
		end

		drain_reports();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("[wheel_slip_detector] OK");
		else
			$display("[wheel_slip_detector] ERROR");
		$finish;
	end

endmodule
